>>> rtl/core/mtrl_pkg.sv
// Shared constants, command codes and interface structs for the multibit trie
// route lookup unit. Used by the walk controller and the top level.
package mtrl_pkg;

    localparam int STRIDE     = 3;
    localparam int FANOUT     = 1 << STRIDE;
    localparam int ADDR_W     = 32;
    localparam int LEVELS     = (ADDR_W + STRIDE - 1) / STRIDE;
    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int USED_W     = NODE_W + 1;
    localparam int ENTRY_W    = NODE_W + STRIDE;
    localparam int PORT_W     = 16;
    localparam int PLEN_W     = 6;
    localparam int CONS_W     = $clog2(LEVELS * STRIDE + 1);
    localparam int LAST_CONS  = (LEVELS - 1) * STRIDE;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    typedef struct packed {
        logic               port_we;
        logic               child_we;
        logic [ENTRY_W-1:0] waddr;
        logic [ENTRY_W-1:0] raddr;
        logic [PORT_W-1:0]  port_wdata;
        logic [NODE_W-1:0]  child_wdata;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        status_t           status;
    } res_t;

endpackage

>>> rtl/core/mtrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mtrl_ram #(
    parameter int WIDTH   = 16,
    parameter int DEPTH_W = 13
) (
    input  logic               clk,
    input  logic               we,
    input  logic [DEPTH_W-1:0] waddr,
    input  logic [WIDTH-1:0]   wdata,
    input  logic [DEPTH_W-1:0] raddr,
    output logic [WIDTH-1:0]   rdata
);

    logic [WIDTH-1:0] mem [2**DEPTH_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mtrl_ctrl.sv
// Trie walk controller: insert and lookup sequencing, node allocation and
// node clearing sweeps over the port and child memories. Depends on mtrl_pkg.
module mtrl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mtrl_pkg::cmd_t                in_cmd,
    input  logic [mtrl_pkg::ADDR_W-1:0]   in_addr,
    input  logic [mtrl_pkg::PLEN_W-1:0]   in_plen,
    input  logic [mtrl_pkg::PORT_W-1:0]   in_port,
    input  logic [mtrl_pkg::PORT_W-1:0]   port_rdata,
    input  logic [mtrl_pkg::NODE_W-1:0]   child_rdata,
    output mtrl_pkg::mem_req_t            mem,
    output mtrl_pkg::res_t                res,
    input  logic                          res_ready
);
    import mtrl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LKP,
        S_INS,
        S_INS_CHK,
        S_EXP_RD,
        S_EXP_WR,
        S_DONE
    } state_t;

    state_t            state_reg,  state_next;
    logic [NODE_W-1:0] node_reg,   node_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [CONS_W-1:0] cons_reg,   cons_next;
    logic [PLEN_W-1:0] plen_reg,   plen_next;
    logic [PORT_W-1:0] port_reg,   port_next;
    logic [USED_W-1:0] used_reg,   used_next;
    logic [STRIDE-1:0] k_reg,      k_next;
    logic [STRIDE-1:0] clr_reg,    clr_next;
    logic [PORT_W-1:0] found_reg,  found_next;
    status_t           status_reg, status_next;

    logic [STRIDE-1:0] chunk;
    logic [STRIDE-1:0] chunk_after;
    logic [STRIDE-1:0] full_mask;
    logic [STRIDE-1:0] exp_mask;
    logic [STRIDE-1:0] exp_idx;
    logic [CONS_W-1:0] rem;
    logic [PORT_W-1:0] found_cur;

    assign full_mask   = '1;
    assign chunk       = addr_reg[ADDR_W-1 -: STRIDE];
    assign chunk_after = addr_reg[ADDR_W-1-STRIDE -: STRIDE];
    assign rem         = CONS_W'(plen_reg) - cons_reg;
    assign exp_mask    = full_mask >> rem;
    assign exp_idx     = (chunk & ~exp_mask) | k_reg;
    assign found_cur   = (port_rdata != '0) ? port_rdata : found_reg;

    always_comb
    begin
        state_next  = state_reg;
        node_next   = node_reg;
        addr_next   = addr_reg;
        cons_next   = cons_reg;
        plen_next   = plen_reg;
        port_next   = port_reg;
        used_next   = used_reg;
        k_next      = k_reg;
        clr_next    = clr_reg;
        found_next  = found_reg;
        status_next = status_reg;

        in_ready        = 1'b0;
        res.valid       = 1'b0;
        res.port        = found_reg;
        res.status      = status_reg;
        mem.port_we     = 1'b0;
        mem.child_we    = 1'b0;
        mem.waddr       = {node_reg, chunk};
        mem.raddr       = {node_reg, chunk};
        mem.port_wdata  = port_reg;
        mem.child_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero one entry of the fresh node per cycle
                mem.port_we    = 1'b1;
                mem.child_we   = 1'b1;
                mem.waddr      = {node_reg, clr_reg};
                mem.port_wdata = '0;
                clr_next       = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = (node_reg == '0) ? S_IDLE : S_INS;
                end
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                mem.raddr = {NODE_W'(0), in_addr[ADDR_W-1 -: STRIDE]};
                if (in_valid)
                begin
                    addr_next   = in_addr;
                    plen_next   = (in_plen > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : in_plen;
                    port_next   = in_port;
                    node_next   = '0;
                    cons_next   = '0;
                    k_next      = '0;
                    found_next  = '0;
                    status_next = STATUS_OK;
                    state_next  = (in_cmd == CMD_LOOKUP) ? S_LKP : S_INS;
                end
            end
            S_LKP:
            begin
                found_next = found_cur;
                if (child_rdata == '0 || cons_reg == CONS_W'(LAST_CONS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // issue the next level's read straight from the child index
                    mem.raddr = {child_rdata, chunk_after};
                    node_next = child_rdata;
                    addr_next = addr_reg << STRIDE;
                    cons_next = cons_reg + CONS_W'(STRIDE);
                end
            end
            S_INS:
            begin
                if (cons_reg >= CONS_W'(plen_reg))
                begin
                    state_next = S_DONE;
                end
                else if (rem < CONS_W'(STRIDE))
                begin
                    mem.raddr  = {node_reg, exp_idx};
                    state_next = S_EXP_WR;
                end
                else if (rem == CONS_W'(STRIDE))
                begin
                    mem.port_we = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                if (child_rdata != '0)
                begin
                    node_next  = child_rdata;
                    addr_next  = addr_reg << STRIDE;
                    cons_next  = cons_reg + CONS_W'(STRIDE);
                    state_next = S_INS;
                end
                else if (used_reg >= USED_W'(NODE_COUNT))
                begin
                    status_next = STATUS_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    // link a fresh node, then sweep it clear
                    mem.child_we    = 1'b1;
                    mem.child_wdata = used_reg[NODE_W-1:0];
                    node_next       = used_reg[NODE_W-1:0];
                    used_next       = used_reg + 1'b1;
                    addr_next       = addr_reg << STRIDE;
                    cons_next       = cons_reg + CONS_W'(STRIDE);
                    clr_next        = '0;
                    state_next      = S_CLEAR;
                end
            end
            S_EXP_RD:
            begin
                mem.raddr  = {node_reg, exp_idx};
                state_next = S_EXP_WR;
            end
            S_EXP_WR:
            begin
                mem.waddr = {node_reg, exp_idx};
                if (port_rdata == '0)
                begin
                    mem.port_we = 1'b1;
                end
                if (k_reg == exp_mask)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_EXP_RD;
                end
            end
            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            node_reg   <= '0;
            used_reg   <= USED_W'(1);
            clr_reg    <= '0;
            k_reg      <= '0;
            cons_reg   <= '0;
            status_reg <= STATUS_OK;
            found_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            node_reg   <= node_next;
            used_reg   <= used_next;
            clr_reg    <= clr_next;
            k_reg      <= k_next;
            cons_reg   <= cons_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        plen_reg <= plen_next;
        port_reg <= port_next;
    end

`ifndef ASSERT_OFF
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 && used_reg <= USED_W'(NODE_COUNT))
        else $error("node count out of range");

    a_sweep_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !(&clr_reg)) |=> (state_reg == S_CLEAR))
        else $error("clear sweep cut short");

    a_link_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (mem.child_we && state_reg != S_CLEAR) |-> (mem.child_wdata != '0))
        else $error("root linked as a child");

    a_no_take_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && res.valid))
        else $error("input taken while a result is pending");

    a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_CHK && $past(state_reg) == S_INS && mem.child_we)
        |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("allocation did not advance node count");
`endif

endmodule

>>> rtl/core/multibit_trie_route_lookup_unit.sv
// Multibit trie route lookup unit, stride 3 over IPv4 addresses.
// Lookup: accept, one read per visited level (at most 11 levels), then the result.
// Insert: accept, a read and a child check per level walked down, a clear sweep per new node,
// then a port write for a full final stride or a read and write per expanded entry, then the result.
// One transaction at a time; the output register frees the walk as soon as a result lands.
// Reset: asynchronous; a sweep then clears the root node with s_tready held low.
module multibit_trie_route_lookup_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address[31:0], prefix_len[37:32], port_value[53:38]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_port[15:0]
    output logic        m_tuser    // status[0]
);
    import mtrl_pkg::*;

    mem_req_t          mem;
    res_t              res;
    logic              res_ready;
    logic [PORT_W-1:0] port_rdata;
    logic [NODE_W-1:0] child_rdata;

    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    status_t           out_status_reg;

    mtrl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (cmd_t'(s_tuser)),
        .in_addr     (s_tdata[ADDR_W-1:0]),
        .in_plen     (s_tdata[ADDR_W+PLEN_W-1:ADDR_W]),
        .in_port     (s_tdata[ADDR_W+PLEN_W+PORT_W-1:ADDR_W+PLEN_W]),
        .port_rdata  (port_rdata),
        .child_rdata (child_rdata),
        .mem         (mem),
        .res         (res),
        .res_ready   (res_ready)
    );

    mtrl_ram #(
        .WIDTH   (PORT_W),
        .DEPTH_W (ENTRY_W)
    ) u_port_ram (
        .clk   (clk),
        .we    (mem.port_we),
        .waddr (mem.waddr),
        .wdata (mem.port_wdata),
        .raddr (mem.raddr),
        .rdata (port_rdata)
    );

    mtrl_ram #(
        .WIDTH   (NODE_W),
        .DEPTH_W (ENTRY_W)
    ) u_child_ram (
        .clk   (clk),
        .we    (mem.child_we),
        .waddr (mem.waddr),
        .wdata (mem.child_wdata),
        .raddr (mem.raddr),
        .rdata (child_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            out_port_reg   <= res.port;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_port_reg;
    assign m_tuser  = out_status_reg;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the multibit trie route lookup unit.
// Depends on mtrl_pkg and multibit_trie_route_lookup_unit; predicts each result
// with its own stride-3 trie and checks each result under random idling on both stream sides.
module tb_top;
    import mtrl_pkg::*;

    localparam int ENTRY_COUNT  = NODE_COUNT * FANOUT;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        status_t           status;
    } route_result_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [31:0]       addr;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
        logic              typed;
        logic [PORT_W-1:0] want_port;
        status_t           want_status;
    } route_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_COIN
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // address[31:0], prefix_len[37:32], port_value[53:38]
    logic        s_tuser;   // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // out_port[15:0]
    logic        m_tuser;   // status[0]

    // Predicted trie state
    logic [PORT_W-1:0] trie_port [ENTRY_COUNT];
    logic [NODE_W-1:0] trie_child [ENTRY_COUNT];
    int                nodes_alloc;

    route_result_t pending_results [$];
    logic [31:0]   route_addrs [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int insert_count   = 0;
    int full_count     = 0;
    int lookup_count   = 0;
    int hit_count      = 0;

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 50;
    int       rx_phase = 0;

    route_result_t got_result;
    route_result_t want_result;

    // Directed rows: empty table, extremes, exact and partial strides,
    // host bits, oversized prefix, zero port, padded final level.
    route_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h0000_0000, 6'd0,  16'h0005, 1'b1, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000, 1'b1, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 1'b1, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, 16'hFFFF, STATUS_OK},
        '{CMD_LOOKUP, 32'hFFFF_FFFE, 6'd63, 16'hFFFF, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'hC0A8_0000, 6'd16, 16'h1234, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'hC0A8_FFFF, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'hC0A8_0000, 6'd15, 16'h2222, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'hC0A8_0101, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h3333, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'hC0A8_8000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h0A00_0000, 6'd63, 16'h0042, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h0A00_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h0A00_0000, 6'd8,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h0A00_0001, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h8000_0000, 6'd1,  16'h0001, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h8000_0000, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h0000_0003, 6'd31, 16'h00AA, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h0000_0002, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_INSERT, 32'h0000_0001, 6'd32, 16'hBBBB, 1'b0, 16'h0000, STATUS_OK},
        '{CMD_LOOKUP, 32'h0000_0001, 6'd0,  16'h0000, 1'b0, 16'h0000, STATUS_OK}
    };

    multibit_trie_route_lookup_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Address chunk at one level, the short last chunk padded at its low end
    function automatic logic [STRIDE-1:0] trie_chunk(input logic [31:0] addr, input int level);
        int          start;
        int          w;
        logic [31:0] v;
        start = level * STRIDE;
        w = ADDR_W - start;
        if (w > STRIDE)
            w = STRIDE;
        v = (addr >> (ADDR_W - start - w)) & ((32'd1 << w) - 32'd1);
        v = v << (STRIDE - w);
        return v[STRIDE-1:0];
    endfunction

    function automatic status_t trie_insert(input logic [31:0] addr, input int plen,
                                            input logic [PORT_W-1:0] port);
        int node;
        int consumed;
        int level;
        int rem;
        int span;
        int base;
        int seg;
        int s;
        int fresh;
        node = 0;
        consumed = 0;
        level = 0;
        while (consumed < plen && level < LEVELS)
        begin
            rem = plen - consumed;
            seg = int'(trie_chunk(addr, level));
            if (rem < STRIDE)
            begin
                // expand over the uncovered low bits, fill empty entries only
                span = 1 << (STRIDE - rem);
                base = seg & ~(span - 1);
                for (int k = 0; k < span; k++)
                begin
                    s = node * FANOUT + base + k;
                    if (trie_port[s] == '0)
                        trie_port[s] = port;
                end
            end
            else if (rem == STRIDE)
                trie_port[node * FANOUT + seg] = port;
            else
            begin
                s = node * FANOUT + seg;
                if (trie_child[s] == '0)
                begin
                    if (nodes_alloc >= NODE_COUNT)
                        return STATUS_FULL;
                    fresh = nodes_alloc;
                    nodes_alloc++;
                    for (int k = 0; k < FANOUT; k++)
                    begin
                        trie_port[fresh * FANOUT + k] = '0;
                        trie_child[fresh * FANOUT + k] = '0;
                    end
                    trie_child[s] = NODE_W'(fresh);
                end
                node = int'(trie_child[s]);
            end
            consumed += STRIDE;
            level++;
        end
        return STATUS_OK;
    endfunction

    function automatic logic [PORT_W-1:0] trie_lookup(input logic [31:0] addr);
        int                node;
        int                s;
        logic [PORT_W-1:0] found;
        node = 0;
        found = '0;
        for (int level = 0; level < LEVELS; level++)
        begin
            s = node * FANOUT + int'(trie_chunk(addr, level));
            if (trie_port[s] != '0)
                found = trie_port[s];
            if (trie_child[s] == '0)
                break;
            node = int'(trie_child[s]);
        end
        return found;
    endfunction

    // Drive one transaction, wait for its handshake, then queue its predicted result
    task automatic send_route(input cmd_t cmd, input logic [31:0] addr,
                              input logic [PLEN_W-1:0] plen, input logic [PORT_W-1:0] port,
                              input logic typed, input route_result_t typed_result);
        route_result_t res;
        int            eff_len;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, port, plen, addr};
        do
            @(posedge clk);
        while (!s_tready);
        res.port = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_INSERT)
        begin
            eff_len = (plen > 32) ? 32 : int'(plen);
            res.status = trie_insert(addr, eff_len, port);
            insert_count++;
            if (res.status == STATUS_FULL)
                full_count++;
        end
        else
        begin
            res.port = trie_lookup(addr);
            lookup_count++;
            if (res.port != '0)
                hit_count++;
        end
        if (typed)
            res = typed_result;
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Receiver: switch between stall patterns every so often
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 300);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE: m_tready <= (rx_phase % 4 == 0);
            default:   m_tready <= 1'($urandom_range(0, 1));
        endcase
        rx_phase <= rx_phase + 1;
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_result.port = m_tdata;
                got_result.status = status_t'(m_tuser);
                if (pending_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected result port=%h status=%0d",
                                 m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want_result = pending_results[0];
                    pending_results.delete(0);
                    if (got_result.port !== want_result.port
                        || got_result.status !== want_result.status)
                    begin
                        if (mismatch_count < 10)
                            $display("ERROR: port exp %h got %h, status exp %0d got %0d",
                                     want_result.port, got_result.port,
                                     want_result.status, got_result.status);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0]       regions [8];
        cmd_t              cmd;
        logic [31:0]       addr;
        logic [31:0]       mask;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
        route_result_t     typed_result;
        int                sent;
        int                burst;
        int                pick;
        int                keep;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        rst_n    = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            trie_port[i] = '0;
            trie_child[i] = '0;
        end
        nodes_alloc = 1;
        for (int i = 0; i < 8; i++)
            regions[i] = $urandom;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            typed_result.port = dir_rows[r].want_port;
            typed_result.status = dir_rows[r].want_status;
            send_route(dir_rows[r].cmd, dir_rows[r].addr, dir_rows[r].plen,
                       dir_rows[r].port, dir_rows[r].typed, typed_result);
        end

        typed_result = '0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                // hold off until the table has answered everything
                if (sent == 400 || sent == 800)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                cmd = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT;
                plen = PLEN_W'($urandom_range(0, 63));
                port = PORT_W'($urandom);
                if (cmd == CMD_INSERT)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        plen = '0;
                    else if (pick == 1)
                        plen = PLEN_W'($urandom_range(33, 63));
                    else if (pick < 10)
                        plen = PLEN_W'($urandom_range(1, 12));
                    else if (pick < 16)
                        plen = PLEN_W'($urandom_range(13, 24));
                    else
                        plen = PLEN_W'($urandom_range(25, 32));
                    // share upper bits with a few regions so subtrees get reused
                    keep = $urandom_range(0, 24);
                    mask = (keep == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - keep));
                    addr = (regions[$urandom_range(0, 7)] & mask) | ($urandom & ~mask);
                    if ($urandom_range(0, 4) == 0)
                        addr = $urandom;
                    port = ($urandom_range(0, 39) == 0) ? 16'h0000
                                                        : PORT_W'($urandom_range(1, 65535));
                    route_addrs.insert(route_addrs.size(), addr);
                    if (route_addrs.size() > 256)
                        route_addrs.delete(0);
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    addr = $urandom;
                    if (pick < 8 && route_addrs.size() != 0)
                    begin
                        addr = route_addrs[$urandom_range(0, route_addrs.size() - 1)];
                        if (pick >= 4)
                        begin
                            keep = $urandom_range(1, 32);
                            mask = (keep == 32) ? 32'hFFFF_FFFF : ((32'd1 << keep) - 32'd1);
                            addr = addr ^ ($urandom & mask);
                        end
                    end
                end
                send_route(cmd, addr, plen, port, 1'b0, typed_result);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d inserts (%0d stopped on a full pool) and %0d lookups (%0d hit).",
                 insert_count, full_count, lookup_count, hit_count);
        $display("Trie nodes in use: %0d of %0d; mismatches: %0d.",
                 nodes_alloc, NODE_COUNT, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
